FILE: rtl/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared types and constants of the current-limited setpoint ramp.
// ----------------------------------------------------------------------------
package clsr_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_FROM     = 3'd0,
        CFG_RAMP_TO       = 3'd1,
        CFG_RAMP_DURATION = 3'd2,
        CFG_CURRENT_LIMIT = 3'd3,
        CFG_ABORT_WINDOW  = 3'd4
    } cfg_idx_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_DONE    = 2'd1,
        ST_ABORTED = 2'd2
    } status_t;

    // Reset value of the abort window in milliseconds
    localparam logic [15:0] ABORT_WINDOW_RESET = 16'd200;

    // Endpoints at most this many LSB apart count as equal
    localparam logic signed [32:0] EQ_TOL = 33'sd6;

    // One quotient digit per mag bit
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

FILE: rtl/clsr_if.sv
// ----------------------------------------------------------------------------
// clsr_if
// Valid/ready channels of the ramp: tick items in, result items out.
// ----------------------------------------------------------------------------
interface clsr_tick_if ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [31:0]        now_ms;
    logic signed [15:0] current_u;
    logic signed [15:0] current_v;

    modport source (output valid, kind, now_ms, current_u, current_v, input ready);
    modport sink   (input valid, kind, now_ms, current_u, current_v, output ready);
endinterface

interface clsr_result_if import clsr_pkg::*; ();
    logic               valid;
    logic               ready;
    status_t            status;
    logic signed [31:0] applied_setpoint;
    logic [16:0]        peak_current;

    modport source (output valid, status, applied_setpoint, peak_current, input ready);
    modport sink   (input valid, status, applied_setpoint, peak_current, output ready);
endinterface

FILE: rtl/current_limited_setpoint_ramp_core.sv
// ----------------------------------------------------------------------------
// current_limited_setpoint_ramp_core
// Linear Q16.16 setpoint ramp with a current-limit pause and abort window.
// ----------------------------------------------------------------------------
// One item at a time. A tick passes from acceptance through a setup step,
// a bit-serial scale unit that forms floor(|to - from| * elapsed / duration)
// one multiplier bit per cycle, then steps to add the offset, decide and load
// the result register. A new item is taken only after the return to idle.
// A tick that resumes from a pause runs setup and the scale unit a second
// time with the shifted start time before the result is loaded.
// A re-arm item goes straight to the load step, and a tick that finishes at
// once (zero duration or equal endpoints) goes from setup to the load step.
// A finished result waits in its own register, so the next item is taken
// while the previous result is still unread; the load step then holds until
// that result is taken. Configuration writes are applied at once and must
// only happen while the block is idle.
module current_limited_setpoint_ramp_core import clsr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    clsr_tick_if.sink             tick,
    clsr_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_DIV  = 6'b000100,
        S_SUM  = 6'b001000,
        S_DEC  = 6'b010000,
        S_LOAD = 6'b100000
    } state_t;

    // Configuration registers
    logic [31:0] ramp_from_reg;
    logic [31:0] ramp_to_reg;
    logic [31:0] duration_reg;
    logic [15:0] current_limit_reg;
    logic [15:0] abort_window_reg;

    // Control and ramp state
    state_t      state_reg,        state_next;
    logic        started_reg,      started_next;
    logic [31:0] start_time_reg,   start_time_next;
    logic [31:0] applied_reg,      applied_next;
    logic        pause_reg,        pause_next;
    logic [31:0] pause_start_reg,  pause_start_next;
    logic        pass2_reg,        pass2_next;
    logic        out_valid_reg,    out_valid_next;
    status_t     status_reg,       status_next;

    // Working payload
    logic [31:0]          now_reg,       now_next;
    logic [16:0]          peak_reg,      peak_next;
    logic                 neg_reg,       neg_next;
    logic                 full_reg,      full_next;
    logic [31:0]          elapsed_reg,   elapsed_next;
    logic [31:0]          pause_len_reg, pause_len_next;
    logic [31:0]          mag_sh_reg,    mag_sh_next;
    logic [31:0]          rem_reg,       rem_next;
    logic [31:0]          quo_reg,       quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg,       cnt_next;
    logic [31:0]          desired_reg,   desired_next;
    status_t              out_status_reg,  out_status_next;
    logic [31:0]          out_applied_reg, out_applied_next;
    logic [16:0]          out_peak_reg,    out_peak_next;

    // Peak phase current of the incoming item; third phase is -(u + v)
    logic signed [16:0] cur_u, cur_v, cur_s;
    logic [16:0]        abs_u, abs_v, abs_w, peak_uv, peak_in;

    assign cur_u   = {tick.current_u[15], tick.current_u};
    assign cur_v   = {tick.current_v[15], tick.current_v};
    assign cur_s   = cur_u + cur_v;
    assign abs_u   = cur_u[16] ? 17'(-cur_u) : 17'(cur_u);
    assign abs_v   = cur_v[16] ? 17'(-cur_v) : 17'(cur_v);
    assign abs_w   = cur_s[16] ? 17'(-cur_s) : 17'(cur_s);
    assign peak_uv = (abs_v > abs_u) ? abs_v : abs_u;
    assign peak_in = (abs_w > peak_uv) ? abs_w : peak_uv;

    // Setup arithmetic: endpoint gap, ramp magnitude and elapsed time
    logic signed [32:0] gap;
    logic [32:0]        gap_abs;
    logic               gap_small;
    logic [31:0]        elapsed_raw;
    logic               elapsed_full;

    assign gap          = $signed({ramp_to_reg[31], ramp_to_reg})
                        - $signed({ramp_from_reg[31], ramp_from_reg});
    assign gap_abs      = gap[32] ? 33'(-gap) : 33'(gap);
    assign gap_small    = (gap <= EQ_TOL) && (gap >= -EQ_TOL);
    assign elapsed_raw  = now_reg - start_time_reg;
    assign elapsed_full = (elapsed_raw >= duration_reg);

    // Scale step: X = 2X + bit * elapsed, keep X = quo * duration + rem
    logic [33:0] step_r;
    logic [33:0] dur_x1, dur_x2;
    logic [31:0] step_rem;
    logic [1:0]  step_digit;

    assign step_r = {1'b0, rem_reg, 1'b0}
                  + (mag_sh_reg[31] ? {2'b00, elapsed_reg} : 34'd0);
    assign dur_x1 = {2'b00, duration_reg};
    assign dur_x2 = {1'b0, duration_reg, 1'b0};

    always_comb
    begin
        if (step_r >= dur_x2)
        begin
            step_rem   = 32'(step_r - dur_x2);
            step_digit = 2'd2;
        end
        else if (step_r >= dur_x1)
        begin
            step_rem   = 32'(step_r - dur_x1);
            step_digit = 2'd1;
        end
        else
        begin
            step_rem   = step_r[31:0];
            step_digit = 2'd0;
        end
    end

    // Decision terms
    logic peak_over, rising, below_resume, pause_too_long;

    assign peak_over      = (peak_reg > {1'b0, current_limit_reg});
    assign rising         = ($signed(desired_reg) > $signed(applied_reg));
    assign below_resume   = (({1'b0, peak_reg, 2'b00} + {3'b000, peak_reg})
                            <= {2'b00, current_limit_reg, 2'b00});
    assign pause_too_long = (pause_len_reg > {16'd0, abort_window_reg});

    logic result_take;
    assign result_take = out_valid_reg && result.ready;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        started_next     = started_reg;
        start_time_next  = start_time_reg;
        applied_next     = applied_reg;
        pause_next       = pause_reg;
        pause_start_next = pause_start_reg;
        pass2_next       = pass2_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        now_next         = now_reg;
        peak_next        = peak_reg;
        neg_next         = neg_reg;
        full_next        = full_reg;
        elapsed_next     = elapsed_reg;
        pause_len_next   = pause_len_reg;
        mag_sh_next      = mag_sh_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        desired_next     = desired_reg;
        out_status_next  = out_status_reg;
        out_applied_next = out_applied_reg;
        out_peak_next    = out_peak_reg;

        // Drop the result once taken
        if (result_take)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick.valid)
                begin
                    now_next    = tick.now_ms;
                    peak_next   = peak_in;
                    status_next = ST_RUNNING;
                    pass2_next  = 1'b0;
                    if (tick.kind)
                    begin
                        // Re-arm: restart from ramp_from
                        applied_next     = ramp_from_reg;
                        started_next     = 1'b0;
                        start_time_next  = 32'd0;
                        pause_next       = 1'b0;
                        pause_start_next = 32'd0;
                        state_next       = S_LOAD;
                    end
                    else
                    begin
                        if (!started_reg)
                        begin
                            start_time_next = tick.now_ms;
                            started_next    = 1'b1;
                        end
                        state_next = S_PREP;
                    end
                end
            end

            S_PREP:
            begin
                if ((duration_reg == 32'd0) || gap_small)
                begin
                    // Finish at once
                    applied_next = ramp_to_reg;
                    status_next  = ST_DONE;
                    state_next   = S_LOAD;
                end
                else
                begin
                    neg_next       = gap[32];
                    mag_sh_next    = gap_abs[31:0];
                    full_next      = elapsed_full;
                    elapsed_next   = elapsed_full ? duration_reg : elapsed_raw;
                    pause_len_next = now_reg - pause_start_reg;
                    rem_next       = 32'd0;
                    quo_next       = 32'd0;
                    cnt_next       = DIV_CNT_W'(DIV_STEPS - 1);
                    state_next     = S_DIV;
                end
            end

            S_DIV:
            begin
                // Advance one bit of the magnitude
                rem_next    = step_rem;
                quo_next    = {quo_reg[30:0], 1'b0} + {30'd0, step_digit};
                mag_sh_next = {mag_sh_reg[30:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SUM;
                end
            end

            S_SUM:
            begin
                desired_next = neg_reg ? (ramp_from_reg - quo_reg)
                                       : (ramp_from_reg + quo_reg);
                state_next   = S_DEC;
            end

            S_DEC:
            begin
                state_next = S_LOAD;
                if (pass2_reg)
                begin
                    // Resumed: apply value at the shifted time
                    applied_next = desired_reg;
                    if (full_reg)
                    begin
                        applied_next = ramp_to_reg;
                        status_next  = ST_DONE;
                    end
                end
                else if (current_limit_reg != 16'd0)
                begin
                    priority if (peak_over && rising)
                    begin
                        // Hold: enter or stay in the pause
                        if (!pause_reg)
                        begin
                            pause_next       = 1'b1;
                            pause_start_next = now_reg;
                        end
                        else if (pause_too_long)
                        begin
                            status_next = ST_ABORTED;
                        end
                    end
                    else if (pause_reg && below_resume)
                    begin
                        // Resume: shift start by the pause and scale again
                        start_time_next = start_time_reg + pause_len_reg;
                        pause_next      = 1'b0;
                        pass2_next      = 1'b1;
                        state_next      = S_PREP;
                    end
                    else if (!pause_reg)
                    begin
                        applied_next = desired_reg;
                        if (full_reg)
                        begin
                            applied_next = ramp_to_reg;
                            status_next  = ST_DONE;
                        end
                    end
                    else
                    begin
                        if (pause_too_long)
                        begin
                            status_next = ST_ABORTED;
                        end
                    end
                end
                else
                begin
                    // Limiting off: follow the ramp
                    pause_next   = 1'b0;
                    applied_next = desired_reg;
                    if (full_reg)
                    begin
                        applied_next = ramp_to_reg;
                        status_next  = ST_DONE;
                    end
                end
            end

            S_LOAD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_status_next  = status_reg;
                    out_applied_next = applied_reg;
                    out_peak_next    = peak_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            started_reg     <= 1'b0;
            start_time_reg  <= 32'd0;
            applied_reg     <= 32'd0;
            pause_reg       <= 1'b0;
            pause_start_reg <= 32'd0;
            pass2_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_RUNNING;
        end
        else
        begin
            state_reg       <= state_next;
            started_reg     <= started_next;
            start_time_reg  <= start_time_next;
            applied_reg     <= applied_next;
            pause_reg       <= pause_next;
            pause_start_reg <= pause_start_next;
            pass2_reg       <= pass2_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        peak_reg        <= peak_next;
        neg_reg         <= neg_next;
        full_reg        <= full_next;
        elapsed_reg     <= elapsed_next;
        pause_len_reg   <= pause_len_next;
        mag_sh_reg      <= mag_sh_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        cnt_reg         <= cnt_next;
        desired_reg     <= desired_next;
        out_status_reg  <= out_status_next;
        out_applied_reg <= out_applied_next;
        out_peak_reg    <= out_peak_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_from_reg     <= 32'd0;
            ramp_to_reg       <= 32'd0;
            duration_reg      <= 32'd0;
            current_limit_reg <= 16'd0;
            abort_window_reg  <= ABORT_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RAMP_FROM:     ramp_from_reg     <= cfg_wdata;
                CFG_RAMP_TO:       ramp_to_reg       <= cfg_wdata;
                CFG_RAMP_DURATION: duration_reg      <= cfg_wdata;
                CFG_CURRENT_LIMIT: current_limit_reg <= cfg_wdata[15:0];
                CFG_ABORT_WINDOW:  abort_window_reg  <= cfg_wdata[15:0];
                default:           ;
            endcase
        end
    end

    // Channel outputs
    assign tick.ready              = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.status           = out_status_reg;
    assign result.applied_setpoint = out_applied_reg;
    assign result.peak_current     = out_peak_reg;

    // An accepted item moves the sequencer into setup or result load
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> (state_reg == S_PREP || state_reg == S_LOAD))
        else $error("accepted item did not start processing");

    // A new result appears only out of the load step
    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOAD))
        else $error("result valid rose outside the load step");

    // The scale unit runs its full count before leaving
    a_div_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg != '0) |=> (state_reg == S_DIV))
        else $error("scale unit left early");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the current-limited setpoint ramp core. A queue-fed
// driver sends tick and re-arm items in random bursts, a clocked monitor
// checks every result item against an in-bench predictor of the ramp, pause,
// resume and abort behavior, over directed cases and random ramp runs.
// ----------------------------------------------------------------------------
module testbench import clsr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_REARM = 1'b1;

    localparam longint SAME_TOL         = 6;
    localparam int     LONG_HOLD_CYCLES = 600;
    localparam int     TAIL_CYCLES      = 100;
    localparam int     RUN_COUNT        = 10;
    localparam int     RUN_ITEMS        = 140;

    typedef struct packed {
        logic        kind;
        logic [31:0] now;
        logic [15:0] u;
        logic [15:0] v;
    } tick_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] setpoint;
        logic [16:0] peak;
    } ramp_result_t;

    typedef enum logic [1:0] {SEG_LOW, SEG_BAND, SEG_OVER} seg_t;
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_BURSTY} sink_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    clsr_tick_if   tick_ch ();
    clsr_result_if res_ch ();

    current_limited_setpoint_ramp_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Register copy held by the predictor
    logic signed [31:0] cf_from     = '0;
    logic signed [31:0] cf_to       = '0;
    logic [31:0]        cf_duration = '0;
    logic [15:0]        cf_limit    = '0;
    logic [15:0]        cf_window   = 16'd200;

    // Ramp state held by the predictor
    logic               rs_started  = 1'b0;
    logic [31:0]        rs_start_ms = '0;
    logic signed [63:0] rs_applied  = '0;
    logic               rs_paused   = 1'b0;
    logic [31:0]        rs_pause_ms = '0;

    tick_item_t   pend_q[$];
    ramp_result_t want_q[$];
    tick_item_t   on_bus;
    ramp_result_t want_r;

    int fail_count      = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int n_settings      = 0;
    int n_rearms        = 0;
    int n_done          = 0;
    int n_aborted       = 0;
    int n_pauses        = 0;
    int n_resumes       = 0;

    int         burst_left         = 0;
    int         gap_left           = 0;
    logic       src_hold           = 1'b0;
    int         long_stalls_asked  = 0;
    int         long_stalls_served = 0;
    int         long_stall_left    = 0;
    sink_mode_t sink_mode          = SINK_OPEN;
    int         mode_left          = 0;
    int         short_stall_left   = 0;
    int         sink_cyc           = 0;

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Elapsed ramp time, clamped to the duration
    function automatic logic [31:0] elapsed_since(logic [31:0] now);
        logic [31:0] e;
        e = now - rs_start_ms;
        return (e > cf_duration) ? cf_duration : e;
    endfunction

    // Setpoint on the straight line at a given elapsed time
    function automatic logic signed [63:0] ramp_value(logic [31:0] el);
        logic signed [63:0] from64;
        logic signed [63:0] diff;
        logic signed [63:0] q64;
        logic [95:0]        prod;
        logic [95:0]        quo;
        from64 = cf_from;
        diff   = cf_to - cf_from;
        prod   = (diff < 0) ? -diff : diff;
        prod   = prod * el;
        quo    = prod / cf_duration;
        q64    = quo[63:0];
        return (diff < 0) ? from64 - q64 : from64 + q64;
    endfunction

    // Advance the ramp state by one item and form its result
    function automatic ramp_result_t predict(tick_item_t it);
        logic signed [17:0] su, sv, sw, au, av, aw;
        logic [16:0]        pk;
        logic signed [63:0] gap, want;
        logic [31:0]        el;
        logic               abort_now;
        ramp_result_t       r;
        su = $signed(it.u);
        sv = $signed(it.v);
        sw = -(su + sv);
        au = (su < 0) ? -su : su;
        av = (sv < 0) ? -sv : sv;
        aw = (sw < 0) ? -sw : sw;
        pk = au[16:0];
        if (av[16:0] > pk) pk = av[16:0];
        if (aw[16:0] > pk) pk = aw[16:0];
        r.status = ST_RUNNING;
        if (it.kind == KIND_REARM)
        begin
            rs_applied  = cf_from;
            rs_started  = 1'b0;
            rs_start_ms = '0;
            rs_paused   = 1'b0;
            rs_pause_ms = '0;
            n_rearms++;
        end
        else
        begin
            gap = cf_from - cf_to;
            if (!rs_started)
            begin
                rs_start_ms = it.now;
                rs_started  = 1'b1;
            end
            if (cf_duration == 0 || (gap <= SAME_TOL && gap >= -SAME_TOL))
            begin
                rs_applied = cf_to;
                r.status   = ST_DONE;
            end
            else
            begin
                el        = elapsed_since(it.now);
                want      = ramp_value(el);
                abort_now = 1'b0;
                if (cf_limit != 0)
                begin
                    if (pk > cf_limit && want > rs_applied)
                    begin
                        if (!rs_paused)
                        begin
                            rs_paused   = 1'b1;
                            rs_pause_ms = it.now;
                            n_pauses++;
                        end
                    end
                    else if (rs_paused &&
                             ({15'b0, pk} * 32'd5) <= ({16'b0, cf_limit} * 32'd4))
                    begin
                        // Shift the start by the pause length and recompute
                        rs_start_ms = rs_start_ms + (it.now - rs_pause_ms);
                        rs_paused   = 1'b0;
                        el          = elapsed_since(it.now);
                        rs_applied  = ramp_value(el);
                        n_resumes++;
                    end
                    else if (!rs_paused)
                    begin
                        rs_applied = want;
                    end
                    if (rs_paused && (it.now - rs_pause_ms) > {16'b0, cf_window})
                        abort_now = 1'b1;
                end
                else
                begin
                    rs_paused  = 1'b0;
                    rs_applied = want;
                end
                if (abort_now)
                begin
                    r.status = ST_ABORTED;
                end
                else if (el >= cf_duration && !rs_paused)
                begin
                    rs_applied = cf_to;
                    r.status   = ST_DONE;
                end
            end
        end
        if (r.status == ST_DONE) n_done++;
        if (r.status == ST_ABORTED) n_aborted++;
        r.setpoint = rs_applied[31:0];
        r.peak     = pk;
        return r;
    endfunction

    // Phase currents whose peak magnitude is exactly pt
    function automatic logic [31:0] currents_for_peak(int pt);
        int a, b, u, v, r;
        a = pt / 2;
        b = pt - a;
        case ($urandom_range(0, 2))
            0:
            begin
                u = -a;
                v = -b;
            end
            1:
            begin
                u = -b;
                v = -a;
            end
            default:
            begin
                if (pt > 32767)
                begin
                    u = -a;
                    v = -b;
                end
                else
                begin
                    r = $urandom_range(0, pt);
                    u = pt;
                    v = -r;
                end
            end
        endcase
        if (b < 32768 && $urandom_range(0, 1) == 1)
        begin
            u = -u;
            v = -v;
        end
        return {u[15:0], v[15:0]};
    endfunction

    task automatic push_item(logic kind, logic [31:0] now, int u, int v);
        tick_item_t it;
        it.kind = kind;
        it.now  = now;
        it.u    = u[15:0];
        it.v    = v[15:0];
        pend_q.push_back(it);
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RAMP_FROM:     cf_from     = val;
            CFG_RAMP_TO:       cf_to       = val;
            CFG_RAMP_DURATION: cf_duration = val;
            CFG_CURRENT_LIMIT: cf_limit    = val[15:0];
            CFG_ABORT_WINDOW:  cf_window   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] from, logic [31:0] to, logic [31:0] dur,
                             logic [15:0] limit, logic [15:0] window);
        write_reg(CFG_RAMP_FROM, from);
        write_reg(CFG_RAMP_TO, to);
        write_reg(CFG_RAMP_DURATION, dur);
        write_reg(CFG_CURRENT_LIMIT, {16'b0, limit});
        write_reg(CFG_ABORT_WINDOW, {16'b0, window});
        n_settings++;
    endtask

    // Wait until every queued item is taken and every result has come back
    task automatic drain_all();
        do @(negedge clk);
        while (pend_q.size() != 0 || tick_ch.valid || want_q.size() != 0);
    endtask

    function automatic logic [31:0] pick_setpoint();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            default: return ($urandom_range(0, 1) ? 32'd1 : -32'sd1) *
                            ($urandom_range(0, 2000) << 16);
        endcase
    endfunction

    // Queue one ramp run: re-arm, then segments of low, in-band and
    // over-limit current with some noise, re-arms and time jumps mixed in
    task automatic fill_ramp_run(int n_items);
        logic [31:0] t;
        logic [31:0] uv;
        seg_t        seg;
        int          seg_left, k, roll, pt, lo_max, step;
        seg      = SEG_LOW;
        seg_left = 0;
        t        = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 150)
                                               : $urandom;
        lo_max   = (4 * int'(cf_limit)) / 5;
        push_item(KIND_REARM, t, 0, 0);
        for (k = 1; k < n_items; k++)
        begin
            if (seg_left == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    seg      = SEG_LOW;
                    seg_left = $urandom_range(3, 30);
                end
                else if (roll < 80)
                begin
                    seg      = SEG_OVER;
                    seg_left = $urandom_range(1, 12);
                end
                else
                begin
                    seg      = SEG_BAND;
                    seg_left = $urandom_range(1, 8);
                end
            end
            seg_left--;
            case (seg)
                SEG_OVER: pt = int'(cf_limit) + 1 + $urandom_range(0, int'(cf_limit) / 4 + 40);
                SEG_BAND: pt = $urandom_range(lo_max + 1, int'(cf_limit));
                default:  pt = $urandom_range(0, lo_max);
            endcase
            if (cf_limit == 0) pt = $urandom_range(0, 40000);
            if (pt > 65536) pt = 65536;
            uv   = currents_for_peak(pt);
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                push_item(KIND_REARM, t, $urandom, $urandom);
            end
            else if (roll < 9)
            begin
                push_item(KIND_TICK, t, $urandom, $urandom);
            end
            else
            begin
                if (roll < 10) t = $urandom;
                push_item(KIND_TICK, t, int'(uv[31:16]), int'(uv[15:0]));
            end
            // Advance time; stretch it while over the limit to reach aborts
            if (seg == SEG_OVER)
            begin
                step = $urandom_range(1, ((cf_window > 4000) ? 500 : cf_window / 8) + 1);
            end
            else
            begin
                roll = $urandom_range(0, 9);
                step = (roll < 8) ? 1 : ((roll == 8) ? 0 : $urandom_range(2, 20));
            end
            t = t + step;
        end
    endtask

    // Driver: offer queued items in bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                want_q.push_back(predict(on_bus));
                items_taken++;
            end
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    tick_ch.valid <= 1'b0;
                end
                else if (pend_q.size() > 0 && !src_hold)
                begin
                    on_bus = pend_q.pop_front();
                    tick_ch.valid     <= 1'b1;
                    tick_ch.kind      <= on_bus.kind;
                    tick_ch.now_ms    <= on_bus.now;
                    tick_ch.current_u <= on_bus.u;
                    tick_ch.current_v <= on_bus.v;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        if ($urandom_range(0, 9) < 4)
                            gap_left = 0;
                        else if ($urandom_range(0, 9) == 0)
                            gap_left = $urandom_range(30, 80);
                        else
                            gap_left = $urandom_range(1, 12);
                    end
                end
                else
                begin
                    tick_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a changing pattern, with long hold-offs on request
    always @(posedge clk)
    begin
        sink_cyc++;
        if (long_stall_left > 0)
        begin
            long_stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (long_stalls_asked > long_stalls_served)
        begin
            long_stalls_served++;
            long_stall_left = LONG_HOLD_CYCLES - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (sink_mode)
                SINK_OPEN:     res_ch.ready <= 1'b1;
                SINK_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
                SINK_PERIODIC: res_ch.ready <= (sink_cyc % 5) != 0;
                default:
                begin
                    if (short_stall_left > 0)
                    begin
                        short_stall_left--;
                        res_ch.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 19) == 0)
                    begin
                        short_stall_left = $urandom_range(1, 25);
                        res_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        res_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Monitor: compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready)
        begin
            if (want_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status %0d setpoint %h peak %h",
                             res_ch.status, res_ch.applied_setpoint, res_ch.peak_current);
            end
            else
            begin
                want_r = want_q.pop_front();
                results_checked++;
                if (res_ch.status !== want_r.status ||
                    res_ch.applied_setpoint !== want_r.setpoint ||
                    res_ch.peak_current !== want_r.peak)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d mismatch: status %0d/%0d setpoint %h/%h peak %h/%h",
                                 results_checked, want_r.status, res_ch.status,
                                 want_r.setpoint, res_ch.applied_setpoint,
                                 want_r.peak, res_ch.peak_current);
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [31:0] base;
        int          p;
        tick_ch.valid     = 1'b0;
        tick_ch.kind      = KIND_TICK;
        tick_ch.now_ms    = '0;
        tick_ch.current_u = '0;
        tick_ch.current_v = '0;
        res_ch.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero duration finishes at once; current extremes
        push_item(KIND_TICK, 32'd0, -32768, -32768);
        push_item(KIND_TICK, 32'hFFFF_FFFF, 32767, 32767);
        push_item(KIND_TICK, 32'd1, -32768, 32767);
        push_item(KIND_REARM, 32'd0, 0, 0);
        drain_all();

        // Full-scale rising ramp: pause, hold, resume at the exact threshold,
        // hold at the limit, abort, finish, and end with a pause pending
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 16'd1000, 16'd5);
        base = 32'd1000;
        push_item(KIND_REARM, base, 0, 0);
        push_item(KIND_TICK, base, 300, -100);
        push_item(KIND_TICK, base + 10, 200, 200);
        push_item(KIND_TICK, base + 11, 1500, 0);
        push_item(KIND_TICK, base + 12, 900, -100);
        push_item(KIND_TICK, base + 13, -800, 0);
        push_item(KIND_TICK, base + 14, 0, 1001);
        push_item(KIND_TICK, base + 15, 1000, 0);
        push_item(KIND_TICK, base + 20, -1200, 0);
        push_item(KIND_REARM, base + 50, 10, 10);
        push_item(KIND_TICK, base + 100, 10, 10);
        push_item(KIND_TICK, base + 250, 10, 10);
        push_item(KIND_TICK, base + 251, 3000, 0);
        push_item(KIND_REARM, base + 260, 0, 0);
        push_item(KIND_TICK, base + 300, 0, 0);
        push_item(KIND_TICK, base + 310, 0, -2000);
        drain_all();

        // Drop the limit while a pause is pending
        write_reg(CFG_CURRENT_LIMIT, 32'd0);
        push_item(KIND_TICK, base + 320, 2000, 0);
        drain_all();

        // Falling ramp of maximum duration across the time wrap
        configure(32'd100 << 16, -(32'sd100 << 16), 32'hFFFF_FFFF, 16'd0, 16'd0);
        push_item(KIND_REARM, 32'hFFFF_FFF0, 0, 0);
        push_item(KIND_TICK, 32'hFFFF_FFF0, 5, 5);
        push_item(KIND_TICK, 32'h0000_0010, 5, 5);
        drain_all();

        // Endpoints within tolerance count as equal
        configure(32'd5, -32'sd1, 32'd50, 16'hFFFF, 16'hFFFF);
        push_item(KIND_REARM, 32'd3, 0, 0);
        push_item(KIND_TICK, 32'd7, 1, 2);
        drain_all();

        // Random ramp runs, a few settings fixed at the extremes
        for (p = 0; p < RUN_COUNT; p++)
        begin
            case (p)
                0: configure(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(50, 150),
                             16'($urandom_range(100, 30000)), 16'($urandom_range(0, 40)));
                1: configure(32'h7FFF_FFFF, 32'h8000_0000, $urandom_range(20, 120),
                             16'hFFFF, 16'd0);
                2: configure(-(32'sd20 << 16), 32'd20 << 16, 32'd1, 16'd1, 16'hFFFF);
                3: configure(pick_setpoint(), pick_setpoint(), $urandom_range(10, 200),
                             16'd0, 16'($urandom_range(0, 40)));
                default:
                begin
                    base = pick_setpoint();
                    configure(base,
                              ($urandom_range(0, 7) == 0) ? base + $urandom_range(0, 16) - 8
                                                          : pick_setpoint(),
                              ($urandom_range(0, 11) == 0) ? 32'd0 : $urandom_range(10, 300),
                              ($urandom_range(0, 5) == 0) ? 16'hFFFF
                                                          : 16'($urandom_range(50, 40000)),
                              ($urandom_range(0, 5) == 0) ? 16'd200
                                                          : 16'($urandom_range(0, 40)));
                end
            endcase
            fill_ramp_run(RUN_ITEMS);
            if (p == 1 || p == 6)
            begin
                // Hold the receiver off while the sender keeps offering items
                do @(negedge clk); while (pend_q.size() > RUN_ITEMS / 2);
                long_stalls_asked++;
            end
            if (p == 4)
            begin
                // Pause the sender until every pending result is back
                do @(negedge clk); while (pend_q.size() > RUN_ITEMS / 2);
                src_hold = 1'b1;
                do @(negedge clk); while (tick_ch.valid || want_q.size() != 0);
                src_hold = 1'b0;
            end
            drain_all();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (want_q.size() != 0) fail_count++;
        $display("covered %0d items (%0d re-arms) over %0d register settings, %0d results checked",
                 items_taken, n_rearms, n_settings, results_checked);
        $display("ramp outcomes: %0d done, %0d aborted, %0d pauses, %0d resumes",
                 n_done, n_aborted, n_pauses, n_resumes);
        if (fail_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
rtl/clsr_pkg.sv
rtl/clsr_if.sv
rtl/current_limited_setpoint_ramp_core.sv
tb/sv/testbench.sv
